@@ rtl/bale_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bale_pkg
// Shared sizes, operation and status codes, and transaction types for the
// bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

  // list capacity and derived widths
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned AMT_CNT_W = $clog2(AMT_W + 1);

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam mode_t MODE_INSERT = 3'd0;
  localparam mode_t MODE_DELETE = 3'd1;
  localparam mode_t MODE_SEARCH = 3'd2;
  localparam mode_t MODE_ROTATE = 3'd3;
  localparam mode_t MODE_DUMP   = 3'd4;

  // status codes
  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_FULL     = 3'd1;
  localparam status_t STAT_EMPTY    = 3'd2;
  localparam status_t STAT_BADPOS   = 3'd3;
  localparam status_t STAT_NOTFOUND = 3'd4;

  // request transaction
  typedef struct packed {
    mode_t                    mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic [AMT_W-1:0]         rotate_amount;
  } bale_in_t;

  // result transaction
  typedef struct packed {
    status_t                  status;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } bale_out_t;

  // remainder unit request
  typedef struct packed {
    logic             start;
    logic [AMT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } bale_div_req_t;

endpackage
`default_nettype wire

@@ rtl/bale_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bale_ram
// Generic single-port-write, single-port-read memory with registered read
// data.
// ----------------------------------------------------------------------------
module bale_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/bale_urem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bale_urem
// Bit-serial restoring remainder unit: rotate amount modulo the entry count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bale_urem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bale_pkg::bale_div_req_t    req_i,
  output logic                       done_o,
  output logic [bale_pkg::CNT_W-1:0] rem_o
);
  import bale_pkg::*;

  logic [AMT_W-1:0]     dvd_q, dvd_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [AMT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 active_q, active_d;
  logic                 done_q, done_d;
  logic [CNT_W:0]       trial;

  // one restoring step per cycle
  always_comb begin
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    trial    = {rem_q, dvd_q[AMT_W-1]};
    if (req_i.start) begin
      dvd_d    = req_i.dividend;
      dvs_d    = req_i.divisor;
      rem_d    = '0;
      cnt_d    = AMT_CNT_W'(AMT_W);
      active_d = 1'b1;
    end else if (active_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      dvd_d = {dvd_q[AMT_W-2:0], 1'b0};
      cnt_d = cnt_q - AMT_CNT_W'(1);
      if (cnt_q == AMT_CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      dvd_q    <= '0;
      dvs_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      dvd_q    <= dvd_d;
      dvs_q    <= dvs_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ rtl/bounded_array_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Fixed-capacity ordered list of signed 32-bit values in block memory, with
// insert, delete, search, rotate and dump operations.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start while busy is low; the request is taken
// at that clock edge. Results appear on res_o for one cycle each, marked by
// res_valid_o; res_o.last flags the final result of a request. The receiver
// cannot stall the block and every result must be captured when shown.
// Entries live in two memory banks with registered read data; the active
// bank is walked one entry per cycle, each write made in the cycle after
// its read. Errors, a rotate of an empty list and unused modes are answered
// without a walk. With n entries, insert at p shifts entries p .. n - 1 up
// and delete at p shifts entries p + 1 .. n - 1 down; an insert at the end
// or a delete of the last entry shifts nothing. A search stops at the first
// match. A dump shows its results one per cycle. A rotate runs the remainder
// unit, then copies the n entries into the other bank, which then becomes
// active.
// busy falls as the final result is shown, so the next request can be taken
// in that cycle. Reset empties the list; memory contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_list_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bale_pkg::bale_in_t  req_i,
  output logic                res_valid_o,
  output bale_pkg::bale_out_t res_o
);
  import bale_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  mode_t             op_q, op_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              bank_q, bank_d;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic [ADDR_W-1:0] dst_q, dst_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              pv_q, pv_d;
  logic [ADDR_W-1:0] pdst_q, pdst_d;
  logic              plast_q, plast_d;
  logic              res_valid_q, res_valid_d;
  bale_out_t         res_q, res_d;

  logic              issue;
  logic              wr_en;
  logic              wr_other;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rdata0, rdata1, rdata;
  logic              we0, we1;

  bale_div_req_t     div_req;
  logic              div_done;
  logic [CNT_W-1:0]  div_rem;

  function automatic bale_out_t mk_res(status_t st, logic [INDEX_W-1:0] idx,
                                       logic [DATA_W-1:0] elem, logic lst);
    bale_out_t r;
    r.status  = st;
    r.index   = idx;
    r.element = elem;
    r.last    = lst;
    return r;
  endfunction

  // rotate amount modulo the entry count
  assign div_req.start    = (state_q == ST_IDLE) && start && (req_i.mode == MODE_ROTATE) &&
                            (count_q != '0);
  assign div_req.dividend = req_i.rotate_amount;
  assign div_req.divisor  = count_q;

  bale_urem u_urem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // read data from the active bank
  assign rdata = bank_q ? rdata1 : rdata0;

  // sequencer: read issue, trailing write or compare, result
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    count_d     = count_q;
    bank_d      = bank_q;
    rd_addr_d   = rd_addr_q;
    dst_d       = dst_q;
    left_d      = left_q;
    pv_d        = 1'b0;
    pdst_d      = pdst_q;
    plast_d     = plast_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_other    = 1'b0;
    wr_addr     = pdst_q;
    wr_data     = rdata;
    issue       = (state_q == ST_WALK) && (left_q != '0);

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d  = req_i.mode;
          val_d = req_i.value;
          pos_d = req_i.position[ADDR_W-1:0];
          unique case (req_i.mode)
            MODE_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_FULL, '0, '0, 1'b1);
              end else if (req_i.position > POS_W'(count_q)) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_BADPOS, '0, '0, 1'b1);
              end else begin
                left_d    = count_q - req_i.position[CNT_W-1:0];
                rd_addr_d = ADDR_W'(count_q - CNT_W'(1));
                dst_d     = count_q[ADDR_W-1:0];
                state_d   = ST_WALK;
              end
            end
            MODE_DELETE: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_EMPTY, '0, '0, 1'b1);
              end else if (req_i.position >= POS_W'(count_q)) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_BADPOS, '0, '0, 1'b1);
              end else begin
                left_d    = count_q - CNT_W'(1) - req_i.position[CNT_W-1:0];
                rd_addr_d = req_i.position[ADDR_W-1:0] + ADDR_W'(1);
                dst_d     = req_i.position[ADDR_W-1:0];
                state_d   = ST_WALK;
              end
            end
            MODE_SEARCH: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_NOTFOUND, '0, '0, 1'b1);
              end else begin
                left_d    = count_q;
                rd_addr_d = '0;
                dst_d     = '0;
                state_d   = ST_WALK;
              end
            end
            MODE_ROTATE: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_OK, '0, '0, 1'b1);
              end else begin
                state_d = ST_DIV;
              end
            end
            MODE_DUMP: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_EMPTY, '0, '0, 1'b1);
              end else begin
                left_d    = count_q;
                rd_addr_d = '0;
                dst_d     = '0;
                state_d   = ST_WALK;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = mk_res(STAT_OK, '0, '0, 1'b1);
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          rd_addr_d = div_rem[ADDR_W-1:0];
          dst_d     = '0;
          left_d    = count_q;
          state_d   = ST_WALK;
        end
      end

      ST_WALK: begin
        // issue the next read
        if (issue) begin
          left_d  = left_q - CNT_W'(1);
          pv_d    = 1'b1;
          pdst_d  = dst_q;
          plast_d = (left_q == CNT_W'(1));
          unique case (op_q) inside
            MODE_INSERT: begin
              rd_addr_d = rd_addr_q - ADDR_W'(1);
              dst_d     = dst_q - ADDR_W'(1);
            end
            MODE_ROTATE: begin
              if (CNT_W'(rd_addr_q) + CNT_W'(1) == count_q) begin
                rd_addr_d = '0;
              end else begin
                rd_addr_d = rd_addr_q + ADDR_W'(1);
              end
              dst_d = dst_q + ADDR_W'(1);
            end
            default: begin
              rd_addr_d = rd_addr_q + ADDR_W'(1);
              dst_d     = dst_q + ADDR_W'(1);
            end
          endcase
        end

        // consume the data read last cycle
        if (pv_q) begin
          unique case (op_q) inside
            MODE_INSERT, MODE_DELETE: begin
              wr_en = 1'b1;
            end
            MODE_ROTATE: begin
              wr_en    = 1'b1;
              wr_other = 1'b1;
            end
            MODE_SEARCH: begin
              if (rdata == val_q) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_OK, INDEX_W'(pdst_q), '0, 1'b1);
                state_d     = ST_IDLE;
                pv_d        = 1'b0;
                left_d      = '0;
              end else if (plast_q) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(STAT_NOTFOUND, '0, '0, 1'b1);
                state_d     = ST_IDLE;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = mk_res(STAT_OK, INDEX_W'(pdst_q), rdata, plast_q);
              if (plast_q) begin
                state_d = ST_IDLE;
              end
            end
          endcase
        end

        // shift or copy finished
        if (!issue && !pv_q &&
            (op_q == MODE_INSERT || op_q == MODE_DELETE || op_q == MODE_ROTATE)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        unique case (op_q) inside
          MODE_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = pos_q;
            wr_data = val_q;
            count_d = count_q + CNT_W'(1);
          end
          MODE_DELETE: begin
            count_d = count_q - CNT_W'(1);
          end
          default: begin
            bank_d = ~bank_q;
          end
        endcase
        res_valid_d = 1'b1;
        res_d       = mk_res(STAT_OK, '0, '0, 1'b1);
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // bank write selects
  assign we0 = wr_en && !(bank_q ^ wr_other);
  assign we1 = wr_en &&  (bank_q ^ wr_other);

  bale_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata0)
  );

  bale_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata1)
  );

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= MODE_INSERT;
      pos_q       <= '0;
      val_q       <= '0;
      count_q     <= '0;
      bank_q      <= 1'b0;
      rd_addr_q   <= '0;
      dst_q       <= '0;
      left_q      <= '0;
      pv_q        <= 1'b0;
      pdst_q      <= '0;
      plast_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      count_q     <= count_d;
      bank_q      <= bank_d;
      rd_addr_q   <= rd_addr_d;
      dst_q       <= dst_d;
      left_q      <= left_d;
      pv_q        <= pv_d;
      pdst_q      <= pdst_d;
      plast_q     <= plast_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
